[hdl/table_cell_slot_placer_macros.svh]
// ----------------------------------------------------------------------------
// table_cell_slot_placer_macros
// Assertion shorthands for the table cell slot placer.
// ----------------------------------------------------------------------------
`ifndef TABLE_CELL_SLOT_PLACER_MACROS_SVH
`define TABLE_CELL_SLOT_PLACER_MACROS_SVH

// same-cycle implication
`define TCSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCSP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/tcsp_pkg.sv]
// ----------------------------------------------------------------------------
// tcsp_pkg
// Types and codes shared by the table cell slot placer modules.
// ----------------------------------------------------------------------------
package tcsp_pkg;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [6:0] col_span;
      logic [6:0] row_span;
      logic       starts_row;
      logic [5:0] lookup_column;
      logic [5:0] lookup_row;
   } req_type;

   typedef struct packed {
      logic [5:0]  column;
      logic [5:0]  row;
      logic [11:0] cell_number;
      logic [6:0]  column_count;
      logic [6:0]  row_count;
      logic        found;
      logic        column_spanned;
      logic        row_spanned;
      logic        error;
   } rsp_type;

   // owner and span marks of one slot
   typedef struct packed {
      logic [11:0] owner;
      logic        row_spanned;
      logic        column_spanned;
   } slot_info_type;

   // write controls into the slot store
   typedef struct packed {
      logic occ_we;
      logic occ_wd;
      logic info_we;
   } mem_ctl_type;

   typedef enum logic [8:0] {
      S_CLEAR   = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_SCAN_RD = 9'b000000100,
      S_SCAN_EV = 9'b000001000,
      S_FILL_RD = 9'b000010000,
      S_FILL_EV = 9'b000100000,
      S_LOOK_RD = 9'b001000000,
      S_LOOK_EV = 9'b010000000,
      S_FINISH  = 9'b100000000
   } state_type;

endpackage

[hdl/tcsp_slot_store.sv]
// ----------------------------------------------------------------------------
// tcsp_slot_store
// Occupancy memory and owner/marks memory, one shared address, registered read.
// ----------------------------------------------------------------------------
module tcsp_slot_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                    clock,
   input  logic [AW-1:0]           addr,
   input  tcsp_pkg::mem_ctl_type   ctl,
   input  tcsp_pkg::slot_info_type info_wd,
   output logic                    occ_rd,
   output tcsp_pkg::slot_info_type info_rd
);

   logic                    occ_mem [DEPTH];
   tcsp_pkg::slot_info_type info_mem [DEPTH];
   logic                    occ_rd_ff;
   tcsp_pkg::slot_info_type info_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.occ_we) begin
         occ_mem[addr] <= ctl.occ_wd;
      end
      if (ctl.info_we) begin
         info_mem[addr] <= info_wd;
      end
      occ_rd_ff  <= occ_mem[addr];
      info_rd_ff <= info_mem[addr];
   end

   assign occ_rd  = occ_rd_ff;
   assign info_rd = info_rd_ff;

endmodule

[hdl/table_cell_slot_placer.sv]
// Lookup: read, evaluate, then finish (out-of-grid goes straight to finish); one item at a time.
// Append: scan S occupied slots and the free start slot, then fill the C x R span;
//   each slot costs one read and one evaluate step on the single store port.
// Refused append: stops during the scan, or at once when the start or a span is bad.
// Reset: synchronous; then a clearing pass over all GRID_COLUMNS*GRID_ROWS slots
//   zeroes the occupancy memory, with req_stall held high.
// ----------------------------------------------------------------------------
// table_cell_slot_placer
// Places table cells into a slot grid held in memory; answers slot lookups.
// ----------------------------------------------------------------------------
`include "table_cell_slot_placer_macros.svh"

module table_cell_slot_placer #(
   parameter int GRID_COLUMNS = 64,
   parameter int GRID_ROWS    = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcsp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcsp_pkg::rsp_type rsp_payload
);

   localparam int SLOTS = GRID_COLUMNS * GRID_ROWS;
   localparam int AW    = $clog2(SLOTS);
   localparam int CW    = $clog2(GRID_COLUMNS);
   localparam int RW    = $clog2(GRID_ROWS);
   localparam int CW1   = $clog2(GRID_COLUMNS + 1);
   localparam int RW1   = $clog2(GRID_ROWS + 1);

   // control
   tcsp_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  addr_ff, addr_in;          // store address, also clear sweep
   logic [AW-1:0]  row_addr_ff, row_addr_in;  // address of first slot of current fill row
   logic [6:0]     c_ff, c_in;                // fill column offset
   logic [6:0]     r_ff, r_in;                // fill row offset

   // item under work
   logic [CW1-1:0] cur_col_ff, cur_col_in;
   logic [RW1-1:0] cur_row_ff, cur_row_in;
   logic [6:0]     cspan_ff, cspan_in;
   logic [6:0]     rspan_ff, rspan_in;
   logic           new_row_ff, new_row_in;

   // placement state
   logic [CW-1:0]  last_col_ff, last_col_in;
   logic [RW-1:0]  last_row_ff, last_row_in;
   logic           any_ff, any_in;
   logic [CW1-1:0] col_count_ff, col_count_in;
   logic [RW1-1:0] row_count_ff, row_count_in;
   logic [11:0]    cells_ff, cells_in;

   // results
   tcsp_pkg::rsp_type res_ff, res_in;
   tcsp_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // store port
   tcsp_pkg::mem_ctl_type   mem_ctl;
   tcsp_pkg::slot_info_type info_wd;
   logic                    occ_rd;
   tcsp_pkg::slot_info_type info_rd;

   // start-position helpers
   logic [CW1-1:0] start_col;
   logic [RW1-1:0] start_row;
   logic           start_bad;
   logic           look_in_grid;
   logic [31:0]    row_sel, col_sel;
   logic [CW1-1:0] scan_next_col;
   logic [31:0]    end_col;
   logic [CW1-1:0] col_count_nxt;
   logic [RW1-1:0] row_count_nxt;

   tcsp_slot_store #(
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .addr    (addr_ff),
      .ctl     (mem_ctl),
      .info_wd (info_wd),
      .occ_rd  (occ_rd),
      .info_rd (info_rd)
   );

   // Start slot before the skip: first cell at the origin, a new-row cell at
   // column 0 of the next row, any other one column right of the last start.
   always_comb begin
      if (!any_ff) begin
         start_col = '0;
         start_row = '0;
      end else if (req_payload.starts_row) begin
         start_col = '0;
         start_row = RW1'(last_row_ff) + RW1'(1);
      end else begin
         start_col = CW1'(last_col_ff) + CW1'(1);
         start_row = RW1'(last_row_ff);
      end
      start_bad = (start_row >= RW1'(GRID_ROWS)) || (start_col >= CW1'(GRID_COLUMNS)) ||
                  (req_payload.col_span == 7'd0) || (req_payload.row_span == 7'd0);
      look_in_grid = (32'(req_payload.lookup_column) < GRID_COLUMNS) &&
                     (32'(req_payload.lookup_row) < GRID_ROWS);
      if (req_payload.cmd == tcsp_pkg::CMD_LOOKUP) begin
         row_sel = 32'(req_payload.lookup_row);
         col_sel = 32'(req_payload.lookup_column);
      end else begin
         row_sel = 32'(start_row);
         col_sel = 32'(start_col);
      end
   end

   assign scan_next_col = cur_col_ff + CW1'(1);
   assign end_col       = 32'(cur_col_ff) + 32'(cspan_ff);
   assign col_count_nxt = (end_col > 32'(col_count_ff)) ? CW1'(end_col) : col_count_ff;
   assign row_count_nxt = new_row_ff ? (row_count_ff + RW1'(1)) : row_count_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      row_addr_in  = row_addr_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cspan_in     = cspan_ff;
      rspan_in     = rspan_ff;
      new_row_in   = new_row_ff;
      last_col_in  = last_col_ff;
      last_row_in  = last_row_ff;
      any_in       = any_ff;
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      cells_in     = cells_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_ctl      = '0;
      info_wd.owner          = cells_ff;
      info_wd.row_spanned    = (r_ff != 7'd0);
      info_wd.column_spanned = (c_ff != 7'd0);

      unique case (state_ff)
         tcsp_pkg::S_CLEAR: begin
            mem_ctl.occ_we = 1'b1;
            mem_ctl.occ_wd = 1'b0;
            addr_in        = addr_ff + AW'(1);
            if (addr_ff == AW'(SLOTS - 1)) begin
               addr_in  = '0;
               state_in = tcsp_pkg::S_IDLE;
            end
         end
         tcsp_pkg::S_IDLE: begin
            if (req_valid) begin
               res_in              = '0;
               res_in.column_count = 7'(col_count_ff);
               res_in.row_count    = 7'(row_count_ff);
               cspan_in   = req_payload.col_span;
               rspan_in   = req_payload.row_span;
               new_row_in = req_payload.starts_row;
               cur_col_in = start_col;
               cur_row_in = start_row;
               addr_in    = AW'(row_sel * GRID_COLUMNS + col_sel);
               if (req_payload.cmd == tcsp_pkg::CMD_LOOKUP) begin
                  state_in = look_in_grid ? tcsp_pkg::S_LOOK_RD : tcsp_pkg::S_FINISH;
               end else if (start_bad) begin
                  res_in.error = 1'b1;
                  state_in     = tcsp_pkg::S_FINISH;
               end else begin
                  state_in = tcsp_pkg::S_SCAN_RD;
               end
            end
         end
         tcsp_pkg::S_SCAN_RD: begin
            state_in = tcsp_pkg::S_SCAN_EV;
         end
         tcsp_pkg::S_SCAN_EV: begin
            if (occ_rd) begin
               // slot taken: step right, refuse at the grid edge
               if (32'(scan_next_col) >= GRID_COLUMNS) begin
                  res_in.error = 1'b1;
                  state_in     = tcsp_pkg::S_FINISH;
               end else begin
                  cur_col_in = scan_next_col;
                  addr_in    = addr_ff + AW'(1);
                  state_in   = tcsp_pkg::S_SCAN_RD;
               end
            end else if ((end_col > 32'(GRID_COLUMNS)) ||
                         (32'(cur_row_ff) + 32'(rspan_ff) > 32'(GRID_ROWS))) begin
               res_in.error = 1'b1;
               state_in     = tcsp_pkg::S_FINISH;
            end else begin
               row_addr_in = addr_ff;
               c_in        = '0;
               r_in        = '0;
               state_in    = tcsp_pkg::S_FILL_RD;
            end
         end
         tcsp_pkg::S_FILL_RD: begin
            state_in = tcsp_pkg::S_FILL_EV;
         end
         tcsp_pkg::S_FILL_EV: begin
            // claim only free slots; taken ones keep their owner
            mem_ctl.occ_we  = !occ_rd;
            mem_ctl.occ_wd  = 1'b1;
            mem_ctl.info_we = !occ_rd;
            if (c_ff != cspan_ff - 7'd1) begin
               c_in     = c_ff + 7'd1;
               addr_in  = addr_ff + AW'(1);
               state_in = tcsp_pkg::S_FILL_RD;
            end else if (r_ff != rspan_ff - 7'd1) begin
               c_in        = '0;
               r_in        = r_ff + 7'd1;
               row_addr_in = row_addr_ff + AW'(GRID_COLUMNS);
               addr_in     = row_addr_ff + AW'(GRID_COLUMNS);
               state_in    = tcsp_pkg::S_FILL_RD;
            end else begin
               col_count_in        = col_count_nxt;
               row_count_in        = row_count_nxt;
               last_col_in         = CW'(cur_col_ff);
               last_row_in         = RW'(cur_row_ff);
               any_in              = 1'b1;
               cells_in            = cells_ff + 12'd1;
               res_in.column       = 6'(cur_col_ff);
               res_in.row          = 6'(cur_row_ff);
               res_in.cell_number  = cells_ff;
               res_in.column_count = 7'(col_count_nxt);
               res_in.row_count    = 7'(row_count_nxt);
               state_in            = tcsp_pkg::S_FINISH;
            end
         end
         tcsp_pkg::S_LOOK_RD: begin
            state_in = tcsp_pkg::S_LOOK_EV;
         end
         tcsp_pkg::S_LOOK_EV: begin
            res_in.found = occ_rd;
            if (occ_rd) begin
               res_in.cell_number    = info_rd.owner;
               res_in.column_spanned = info_rd.column_spanned;
               res_in.row_spanned    = info_rd.row_spanned;
            end
            state_in = tcsp_pkg::S_FINISH;
         end
         tcsp_pkg::S_FINISH: begin
            // hand over once the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = tcsp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tcsp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcsp_pkg::S_CLEAR;
         addr_ff      <= '0;
         last_col_ff  <= '0;
         last_row_ff  <= '0;
         any_ff       <= 1'b0;
         col_count_ff <= '0;
         row_count_ff <= '0;
         cells_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
         any_ff       <= any_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         cells_ff     <= cells_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and per-item working registers
   always_ff @(posedge clock) begin
      row_addr_ff <= row_addr_in;
      c_ff        <= c_in;
      r_ff        <= r_in;
      cur_col_ff  <= cur_col_in;
      cur_row_ff  <= cur_row_in;
      cspan_ff    <= cspan_in;
      rspan_ff    <= rspan_in;
      new_row_ff  <= new_row_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall   = (state_ff != tcsp_pkg::S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // fill address tracks row base plus column offset
   `TCSP_ASSERT_IMP(a_fill_addr, clock, reset, state_ff == tcsp_pkg::S_FILL_EV, addr_ff == AW'(row_addr_ff + AW'(c_ff)), "fill address off its span")
   // skip never walks off the grid
   `TCSP_ASSERT_IMP(a_scan_col, clock, reset, state_ff == tcsp_pkg::S_SCAN_EV, 32'(cur_col_ff) < GRID_COLUMNS, "scan column outside grid")
   // output register loads only from the finish step
   `TCSP_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_valid_ff), $past(state_ff == tcsp_pkg::S_FINISH), "result raised outside finish")
   `TCSP_ASSERT_NXT(a_rsp_load, clock, reset, (state_ff == tcsp_pkg::S_FINISH) && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff && (rsp_ff == $past(res_ff)), "result not handed over")

endmodule

[sim/tb_table_cell_slot_placer.sv]
// ----------------------------------------------------------------------------
// tb_table_cell_slot_placer
// Self-checking bench for the table cell slot placer. A local grid model
// predicts the answer to every accepted item; a monitor compares each answer
// field by field against the oldest prediction. Directed placements cover the
// span extremes, refusals, overlap and both span marks, then random tables
// run under several sender/receiver idle mixes plus a long receiver hold.
// ----------------------------------------------------------------------------
module tb_table_cell_slot_placer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_COLUMNS  = 64;
   localparam int GRID_ROWS     = 64;
   localparam int SLOT_TOTAL    = GRID_COLUMNS * GRID_ROWS;
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 100;   // quiet time once all answers are in
   localparam int REPORT_LIMIT  = 10;

   // ------------------------------------------------------------------------
   // clock, reset and DUT ports
   // ------------------------------------------------------------------------
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   tcsp_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   tcsp_pkg::rsp_type rsp_payload;

   always #5 clock = ~clock;

   table_cell_slot_placer #(
      .GRID_COLUMNS (GRID_COLUMNS),
      .GRID_ROWS    (GRID_ROWS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // ------------------------------------------------------------------------
   // grid model: occupancy, owner and span marks per slot, plus the
   // placement cursor and the running counts
   // ------------------------------------------------------------------------
   bit          taken_map [SLOT_TOTAL] = '{default: 1'b0};
   logic [11:0] owner_map [SLOT_TOTAL];
   logic [1:0]  marks_map [SLOT_TOTAL];   // {row spanned, column spanned}
   int          anchor_col   = 0;         // start slot of the last placed cell
   int          anchor_row   = 0;
   bit          seen_cell    = 1'b0;
   logic [6:0]  width_so_far = '0;
   logic [6:0]  rows_so_far  = '0;
   logic [12:0] cells_so_far = '0;

   tcsp_pkg::rsp_type awaited_answers [$];

   // idle mix for the current phase, in percent
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   int mismatch_count = 0;

   // long hold-off: a test bumps hold_token, the receiver process sees the
   // change and holds rsp_stall high while hold_left, loaded from HOLD_CYCLES, counts down
   int hold_token      = 0;
   int hold_token_seen = 0;
   int hold_left       = 0;

   // Works out the answer the block owes for one item and advances the grid.
   function automatic tcsp_pkg::rsp_type grid_answer(input tcsp_pkg::req_type item);
      tcsp_pkg::rsp_type ans;
      int      col;
      int      row;
      int      cs;
      int      rs;
      int      idx;
      bit      refused;
      ans     = '0;
      col     = 0;
      row     = 0;
      refused = 1'b0;
      if (item.cmd == tcsp_pkg::CMD_LOOKUP) begin
         ans.column_count = width_so_far;
         ans.row_count    = rows_so_far;
         col = int'(item.lookup_column);
         row = int'(item.lookup_row);
         if (col < GRID_COLUMNS && row < GRID_ROWS) begin
            idx = row * GRID_COLUMNS + col;
            if (taken_map[idx]) begin
               ans.cell_number    = owner_map[idx];
               ans.found          = 1'b1;
               ans.column_spanned = marks_map[idx][0];
               ans.row_spanned    = marks_map[idx][1];
            end
         end
         return ans;
      end

      // append: first cell at the origin, else next row or next column,
      // then skip right past anything already claimed
      if (seen_cell) begin
         if (item.starts_row) begin
            col = 0;
            row = anchor_row + 1;
         end else begin
            col = anchor_col + 1;
            row = anchor_row;
         end
         if (row >= GRID_ROWS || col >= GRID_COLUMNS)
            refused = 1'b1;
         while (!refused && taken_map[row * GRID_COLUMNS + col]) begin
            col++;
            if (col >= GRID_COLUMNS)
               refused = 1'b1;
         end
      end
      cs = int'(item.col_span);
      rs = int'(item.row_span);
      if (cs == 0 || rs == 0)
         refused = 1'b1;
      if (!refused && (col + cs > GRID_COLUMNS || row + rs > GRID_ROWS))
         refused = 1'b1;

      if (refused) begin
         ans.column_count = width_so_far;
         ans.row_count    = rows_so_far;
         ans.error        = 1'b1;
         return ans;
      end

      // claim the free slots of the span; claimed ones keep their owner
      for (int r = 0; r < rs; r++) begin
         for (int c = 0; c < cs; c++) begin
            idx = (row + r) * GRID_COLUMNS + col + c;
            if (!taken_map[idx]) begin
               taken_map[idx] = 1'b1;
               owner_map[idx] = cells_so_far[11:0];
               marks_map[idx] = {r != 0, c != 0};
            end
         end
      end
      if (col + cs > int'(width_so_far))
         width_so_far = 7'(col + cs);
      if (item.starts_row)
         rows_so_far = rows_so_far + 7'd1;

      ans.column       = 6'(col);
      ans.row          = 6'(row);
      ans.cell_number  = cells_so_far[11:0];
      ans.column_count = width_so_far;
      ans.row_count    = rows_so_far;

      anchor_col   = col;
      anchor_row   = row;
      seen_cell    = 1'b1;
      cells_so_far = cells_so_far + 13'd1;
      return ans;
   endfunction

   function automatic bit answers_agree(input tcsp_pkg::rsp_type want,
                                        input tcsp_pkg::rsp_type got);
      return (got.column         === want.column)         &&
             (got.row            === want.row)            &&
             (got.cell_number    === want.cell_number)    &&
             (got.column_count   === want.column_count)   &&
             (got.row_count      === want.row_count)      &&
             (got.found          === want.found)          &&
             (got.column_spanned === want.column_spanned) &&
             (got.row_spanned    === want.row_spanned)    &&
             (got.error          === want.error);
   endfunction

   // ------------------------------------------------------------------------
   // item builders; unused fields of an item carry random noise
   // ------------------------------------------------------------------------
   function automatic tcsp_pkg::req_type append_item(input int cs, input int rs,
                                                     input bit new_row);
      tcsp_pkg::req_type item;
      item.cmd           = tcsp_pkg::CMD_APPEND;
      item.col_span      = 7'(cs);
      item.row_span      = 7'(rs);
      item.starts_row    = new_row;
      item.lookup_column = 6'($urandom);
      item.lookup_row    = 6'($urandom);
      return item;
   endfunction

   function automatic tcsp_pkg::req_type lookup_item(input int col, input int row);
      tcsp_pkg::req_type item;
      item.cmd           = tcsp_pkg::CMD_LOOKUP;
      item.col_span      = 7'($urandom);
      item.row_span      = 7'($urandom);
      item.starts_row    = 1'($urandom);
      item.lookup_column = 6'(col);
      item.lookup_row    = 6'(row);
      return item;
   endfunction

   // Mostly table-like rows: small spans, a new row now and then; a few
   // wide, tall or out-of-range spans. Lookups lean toward filled rows.
   function automatic tcsp_pkg::req_type random_item();
      tcsp_pkg::req_type item;
      int      pick;
      int      row_hint;
      item.cmd = ($urandom_range(99) < 25) ? tcsp_pkg::CMD_LOOKUP : tcsp_pkg::CMD_APPEND;
      pick = $urandom_range(99);
      if (pick < 70)
         item.col_span = 7'($urandom_range(1, 3));
      else if (pick < 90)
         item.col_span = 7'($urandom_range(4, 10));
      else if (pick < 98)
         item.col_span = 7'($urandom_range(1, 64));
      else
         item.col_span = 7'($urandom_range(0, 127));
      pick = $urandom_range(99);
      if (pick < 75)
         item.row_span = 7'd1;
      else if (pick < 93)
         item.row_span = 7'($urandom_range(2, 3));
      else if (pick < 98)
         item.row_span = 7'($urandom_range(1, 8));
      else
         item.row_span = 7'($urandom_range(0, 127));
      item.starts_row    = ($urandom_range(99) < 8);
      item.lookup_column = 6'($urandom_range(63));
      row_hint = (anchor_row + 1 > 63) ? 63 : anchor_row + 1;
      if ($urandom_range(1) == 0)
         item.lookup_row = 6'($urandom_range(63));
      else
         item.lookup_row = 6'($urandom_range(row_hint));
      return item;
   endfunction

   // ------------------------------------------------------------------------
   // sender: optional idle gap, then hold the item until accepted. Returns
   // in the accept step with valid still high, so the next call can keep
   // valid up without a low/high pair in one step.
   // ------------------------------------------------------------------------
   task automatic offer_item(input tcsp_pkg::req_type item);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      awaited_answers.push_back(grid_answer(item));
   endtask

   // sender pause: drop valid and wait for every owed answer
   task automatic settle_grid();
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // receiver: long hold when asked, else random stall at the phase rate
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_token != hold_token_seen) begin
         hold_token_seen <= hold_token;
         hold_left       <= HOLD_CYCLES;
         rsp_stall       <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // monitor: every accepted answer against the oldest prediction
   // ------------------------------------------------------------------------
   tcsp_pkg::rsp_type answer_due;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: answer with nothing owed: %p", $realtime, rsp_payload);
         end else begin
            answer_due = awaited_answers.pop_front();
            if (!answers_agree(answer_due, rsp_payload)) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: mismatch expected %p", $realtime, answer_due);
                  $display("%0t:          actual   %p", $realtime, rsp_payload);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // Spans at their limits and the refusal paths for spans and the skip, from an empty grid.
   task automatic test_span_limits();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      offer_item(append_item(1, 64, 1'b1));    // full-height cell in column 0
      offer_item(append_item(64, 1, 1'b0));    // runs off the right edge
      offer_item(append_item(63, 1, 1'b0));    // fills the rest of row 0
      offer_item(append_item(1, 1, 1'b0));     // skip walks off the grid
      offer_item(append_item(0, 1, 1'b1));     // zero column span
      offer_item(append_item(1, 0, 1'b1));     // zero row span
      offer_item(append_item(127, 1, 1'b1));   // column span beyond range
      offer_item(append_item(1, 127, 1'b1));   // row span beyond range
      offer_item(append_item(1, 64, 1'b1));    // runs off the bottom
   endtask

   // Overlap with a row-spanning cell, a tall cell, and lookups of each
   // kind of slot.
   task automatic test_overlap_and_lookups();
      offer_item(append_item(1, 1, 1'b1));     // row 1 skips column 0
      offer_item(append_item(1, 1, 1'b0));
      offer_item(append_item(1, 2, 1'b0));     // reaches down into row 2
      offer_item(append_item(4, 1, 1'b1));     // row 2 span crosses that slot
      offer_item(append_item(2, 62, 1'b0));    // tall cell down to the last row
      offer_item(lookup_item(0, 0));
      offer_item(lookup_item(0, 63));          // row spanned
      offer_item(lookup_item(63, 0));          // column spanned
      offer_item(lookup_item(3, 2));           // kept by the earlier owner
      offer_item(lookup_item(4, 2));
      offer_item(lookup_item(6, 63));          // both marks
      offer_item(lookup_item(63, 63));         // never claimed
      offer_item(lookup_item(10, 1));
   endtask

   // Receiver holds for a long stretch while the sender keeps offering,
   // then the sender waits for the block to drain completely.
   task automatic test_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_token++;
      repeat (12) offer_item(random_item());
      settle_grid();
   endtask

   task automatic test_random_tables(input int idle_pct, input int stall_pct,
                                     input int count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) offer_item(random_item());
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // the block clears its occupancy store after reset with req_stall high;
      // the first handshake simply waits that out

      test_span_limits();
      test_overlap_and_lookups();
      test_random_tables(0, 0, 345);
      test_backpressure();
      test_random_tables(45, 0, 345);
      test_random_tables(0, 45, 345);
      test_random_tables(15, 15, 345);
      settle_grid();

      if (awaited_answers.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
